// ----- src/tws_pkg.sv -----
package tws_pkg;

	localparam int BUF_DEPTH  = 1024;
	localparam int POOL_DEPTH = 64;

	localparam logic [2:0] FN_TICK    = 3'd0;
	localparam logic [2:0] FN_SCH_CUR = 3'd1;
	localparam logic [2:0] FN_SCH_REF = 3'd2;
	localparam logic [2:0] FN_CLEAR   = 3'd3;
	localparam logic [2:0] FN_SET     = 3'd4;

	localparam logic [1:0] KIND_EVENT  = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_LATE   = 3'd1;
	localparam logic [2:0] ST_FAR    = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_NO_REF = 3'd4;

	typedef logic [2:0] status_t;

endpackage

// ----- src/tatum_timing_wheel_scheduler_unit.sv -----
// Schedule: S_SCHK, S_SRD, S_SWR, status; rejected at S_SCHK; set tick, unused codes: status.
// Tick: S_TRD, S_THEAD, S_TEV before first word; per due event S_TDAT, S_TEV (next-link read).
// Clear: one slot per cycle over max(BUF_DEPTH, POOL_DEPTH) entries, then status.
// One item at a time; input is taken only when the previous item has finished.
// After reset a sweep over max(BUF_DEPTH, POOL_DEPTH) entries empties the slots
// and chains the free list; no input is taken until it ends.
module tatum_timing_wheel_scheduler_unit #(
	parameter int BUF_DEPTH  = tws_pkg::BUF_DEPTH,
	parameter int POOL_DEPTH = tws_pkg::POOL_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // offset, event_tag, payload, tatum_value
	input  logic [2:0]   s_tuser,  // func
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // out_tag, out_payload, tatum, status, pad
	output logic [1:0]   m_tuser,  // kind
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	localparam int SW    = $clog2(BUF_DEPTH);
	localparam int IW    = $clog2(POOL_DEPTH);
	localparam int LW    = $clog2(POOL_DEPTH + 1);
	localparam int SWEEP = (BUF_DEPTH > POOL_DEPTH) ? BUF_DEPTH : POOL_DEPTH;
	localparam int CW    = $clog2(SWEEP);
	localparam logic [LW-1:0] NONE = LW'(POOL_DEPTH);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_SCHK   = 4'd2;
	localparam logic [3:0] S_SRD    = 4'd3;
	localparam logic [3:0] S_SWR    = 4'd4;
	localparam logic [3:0] S_TRD    = 4'd5;
	localparam logic [3:0] S_THEAD  = 4'd6;
	localparam logic [3:0] S_TEV    = 4'd7;
	localparam logic [3:0] S_TDAT   = 4'd8;
	localparam logic [3:0] S_TEND   = 4'd9;
	localparam logic [3:0] S_CLR    = 4'd10;
	localparam logic [3:0] S_STAT   = 4'd11;

	logic [3:0]    state_q;
	logic [31:0]   ref_q;
	logic [31:0]   cur_q;
	logic [SW-1:0] rp_q;
	logic [IW-1:0] free_head_q;
	logic [IW-1:0] free_tail_q;
	logic [CW-1:0] cnt_q;
	logic [LW-1:0] e_q;
	logic [SW-1:0] slot_q;
	tws_pkg::status_t st_q;

	logic [2:0]  func_q;
	logic [31:0] offset_q;
	logic [31:0] tag_q;
	logic [31:0] pay_q;
	logic [31:0] tval_q;

	logic        o_valid_q;
	logic [1:0]  o_kind_q;
	logic [31:0] o_tag_q;
	logic [31:0] o_pay_q;
	logic [31:0] o_tatum_q;
	logic [2:0]  o_st_q;
	logic        o_last_q;

	logic [LW-1:0] slot_mem [BUF_DEPTH];
	logic [LW-1:0] link_mem [POOL_DEPTH];
	logic [31:0]   tag_mem  [POOL_DEPTH];
	logic [31:0]   pay_mem  [POOL_DEPTH];
	logic [LW-1:0] sh_rd;
	logic [LW-1:0] nl_rd;
	logic [31:0]   tag_rd;
	logic [31:0]   pay_rd;

	logic          can_emit;
	logic          out_load;
	logic          sweep_end;
	logic [IW-1:0] pool_ra;
	logic [SW-1:0] slot_ra;
	logic signed [33:0] delta;
	logic [31:0]   base;
	logic [SW:0]   ssum;
	logic [SW-1:0] starget;

	assign can_emit  = !o_valid_q || m_tready;
	assign out_load  = can_emit && (state_q inside {S_TDAT, S_TEND, S_STAT});
	assign sweep_end = (cnt_q == CW'(SWEEP - 1));
	assign s_tready  = (state_q == S_IDLE);

	assign base = (func_q == tws_pkg::FN_SCH_REF) ? ref_q : cur_q;
	assign delta = $signed({{2{offset_q[31]}}, offset_q}) + $signed({{2{base[31]}}, base})
		- $signed({{2{cur_q[31]}}, cur_q});
	assign ssum = {1'b0, rp_q} + delta[SW:0];
	assign starget = (ssum >= (SW+1)'(BUF_DEPTH)) ? SW'(ssum - (SW+1)'(BUF_DEPTH))
		: ssum[SW-1:0];

	assign pool_ra = (state_q == S_SRD) ? free_head_q : e_q[IW-1:0];
	assign slot_ra = (state_q == S_TRD) ? rp_q : slot_q;

	always_ff @(posedge clk) begin
		sh_rd  <= slot_mem[slot_ra];
		nl_rd  <= link_mem[pool_ra];
		tag_rd <= tag_mem[pool_ra];
		pay_rd <= pay_mem[pool_ra];
		if ((state_q == S_INIT || state_q == S_CLR) && int'(cnt_q) < BUF_DEPTH) begin
			slot_mem[cnt_q[SW-1:0]] <= NONE;
		end else if (state_q == S_TEND && can_emit) begin
			slot_mem[rp_q] <= NONE;
		end else if (state_q == S_SWR) begin
			slot_mem[slot_q] <= LW'(free_head_q);
		end
		if ((state_q == S_INIT || state_q == S_CLR) && int'(cnt_q) < POOL_DEPTH) begin
			link_mem[cnt_q[IW-1:0]] <= (cnt_q == CW'(POOL_DEPTH - 1)) ? NONE
				: LW'(cnt_q + CW'(1));
		end else if (state_q == S_TDAT && can_emit) begin
			link_mem[free_tail_q] <= e_q;
		end else if (state_q == S_SWR) begin
			link_mem[free_head_q] <= sh_rd;
		end
		if (state_q == S_SWR) begin
			tag_mem[free_head_q] <= tag_q;
			pay_mem[free_head_q] <= pay_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q   <= s_tuser;
			offset_q <= s_tdata[31:0];
			tag_q    <= s_tdata[63:32];
			pay_q    <= s_tdata[95:64];
			tval_q   <= s_tdata[127:96];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			ref_q       <= '1;
			cur_q       <= '0;
			rp_q        <= '0;
			free_head_q <= '0;
			free_tail_q <= IW'(POOL_DEPTH - 1);
			cnt_q       <= '0;
			e_q         <= NONE;
			slot_q      <= '0;
			st_q        <= tws_pkg::ST_OK;
			o_valid_q   <= 1'b0;
			o_kind_q    <= tws_pkg::KIND_STATUS;
			o_tag_q     <= '0;
			o_pay_q     <= '0;
			o_tatum_q   <= '0;
			o_st_q      <= tws_pkg::ST_OK;
			o_last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				ref_q <= cfg_wdata;
			end
			if (out_load) begin
				o_valid_q <= 1'b1;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT, S_CLR: begin
					cnt_q <= sweep_end ? '0 : cnt_q + CW'(1);
					if (sweep_end) begin
						free_head_q <= '0;
						free_tail_q <= IW'(POOL_DEPTH - 1);
						st_q        <= tws_pkg::ST_OK;
						state_q     <= (state_q == S_INIT) ? S_IDLE : S_STAT;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						st_q <= tws_pkg::ST_OK;
						case (s_tuser)
							tws_pkg::FN_TICK:    state_q <= S_TRD;
							tws_pkg::FN_SCH_CUR: state_q <= S_SCHK;
							tws_pkg::FN_SCH_REF: state_q <= S_SCHK;
							tws_pkg::FN_CLEAR:   state_q <= S_CLR;
							default:             state_q <= S_STAT;
						endcase
					end
				end
				S_SCHK: begin
					slot_q <= starget;
					if (func_q == tws_pkg::FN_SCH_REF && ref_q[31]) begin
						st_q    <= tws_pkg::ST_NO_REF;
						state_q <= S_STAT;
					end else if (delta < 34'sd0) begin
						st_q    <= tws_pkg::ST_LATE;
						state_q <= S_STAT;
					end else if (delta >= $signed(34'(BUF_DEPTH))) begin
						st_q    <= tws_pkg::ST_FAR;
						state_q <= S_STAT;
					end else if (free_head_q == free_tail_q) begin
						st_q    <= tws_pkg::ST_FULL;
						state_q <= S_STAT;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					free_head_q <= nl_rd[IW-1:0];
					state_q     <= S_STAT;
				end
				S_TRD: state_q <= S_THEAD;
				S_THEAD: begin
					e_q     <= sh_rd;
					state_q <= S_TEV;
				end
				S_TEV: state_q <= (e_q == NONE) ? S_TEND : S_TDAT;
				S_TDAT: begin
					if (can_emit) begin
						o_kind_q    <= tws_pkg::KIND_EVENT;
						o_tag_q     <= tag_rd;
						o_pay_q     <= pay_rd;
						o_tatum_q   <= '0;
						o_st_q      <= tws_pkg::ST_OK;
						o_last_q    <= 1'b0;
						free_tail_q <= e_q[IW-1:0];
						e_q         <= nl_rd;
						state_q     <= S_TEV;
					end
				end
				S_TEND: begin
					if (can_emit) begin
						o_kind_q  <= tws_pkg::KIND_TICK;
						o_tag_q   <= '0;
						o_pay_q   <= '0;
						o_tatum_q <= cur_q;
						o_st_q    <= tws_pkg::ST_OK;
						o_last_q  <= 1'b1;
						cur_q     <= cur_q + 32'd1;
						rp_q      <= (rp_q == SW'(BUF_DEPTH - 1)) ? '0 : rp_q + SW'(1);
						state_q   <= S_IDLE;
					end
				end
				S_STAT: begin
					if (can_emit) begin
						if (func_q == tws_pkg::FN_SET) begin
							cur_q <= tval_q;
						end
						o_kind_q  <= tws_pkg::KIND_STATUS;
						o_tag_q   <= '0;
						o_pay_q   <= '0;
						o_tatum_q <= '0;
						o_st_q    <= st_q;
						o_last_q  <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {5'd0, o_st_q, o_tatum_q, o_pay_q, o_tag_q};
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;

`ifndef NO_ASSERTIONS
	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q < SW'(BUF_DEPTH - 1) || rp_q == SW'(BUF_DEPTH - 1))
		else $error("ring position out of range");
	a_alloc_spare: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWR |-> free_head_q != free_tail_q)
		else $error("allocation from a full pool");
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TDAT |-> e_q < NONE)
		else $error("walk on an invalid entry");
	a_stat_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STAT && can_emit) |=> (o_valid_q && o_last_q && s_tready))
		else $error("status word not issued");
`endif

endmodule
